// ===== sv/y2r_pkg.sv =====
// ----------------------------------------------------------------------------
// y2r_pkg
// Shared types, constants and helpers of the 4:2:0 block to RGB converter.
// ----------------------------------------------------------------------------
`default_nettype none

package y2r_pkg;

	// Widths of the arithmetic and of the position counters.
	localparam int SUM_W   = 28;
	localparam int COEF_W  = 19;
	localparam int FRAC_W  = 16;
	localparam int CNT_W   = 11;
	localparam int COORD_W = 12;
	localparam int DIM_W   = 13;
	localparam int BLK_W   = 13;
	localparam int CFG_IDX_W = 2;

	// Depth of the block queue between the front and the back.
	localparam int Q_DEPTH = 2;
	localparam int Q_PTR_W = $clog2(Q_DEPTH);

	// BT.601 coefficients with 16 fraction bits.
	localparam logic signed [COEF_W-1:0] K_YT = 19'sd76309;
	localparam logic signed [COEF_W-1:0] K_RV = 19'sd104597;
	localparam logic signed [COEF_W-1:0] K_GU = 19'sd25675;
	localparam logic signed [COEF_W-1:0] K_GV = 19'sd53279;
	localparam logic signed [COEF_W-1:0] K_BU = 19'sd132201;

	// Sample offsets.
	localparam logic signed [8:0] LUMA_OFFSET   = 9'sd16;
	localparam logic signed [8:0] CHROMA_OFFSET = 9'sd128;

	// Reset values of the frame size registers.
	localparam logic [DIM_W-1:0] WIDTH_RESET  = 13'd176;
	localparam logic [DIM_W-1:0] HEIGHT_RESET = 13'd144;

	// Luma slots in the order the pixels leave the block.
	localparam int SLOT_TL = 0;
	localparam int SLOT_BL = 1;
	localparam int SLOT_TR = 2;
	localparam int SLOT_BR = 3;

	// Configuration register indexes.
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_FRAME_WIDTH  = 2'd0,
		CFG_FRAME_HEIGHT = 2'd1
	} cfg_idx_t;

	typedef logic signed [SUM_W-1:0] term_t;

	// One block as it waits in the queue: lumas, shared chroma terms, position and frame end flag.
	typedef struct packed {
		logic [3:0][7:0]  luma;
		term_t            rv;
		term_t            gu;
		term_t            gv;
		term_t            bu;
		logic [CNT_W-1:0] col;
		logic [CNT_W-1:0] row;
		logic             frame_end;
	} blk_entry_t;

	typedef struct packed {
		logic       valid;
		blk_entry_t entry;
	} q_port_t;

	// Frame size in blocks.
	typedef struct packed {
		logic [BLK_W-1:0] cols;
		logic [BLK_W-1:0] rows;
	} dims_t;

	// Arithmetic shift by the fraction bits, then clamp to 0..255.
	function automatic logic [7:0] clamp8(input term_t x);
		logic signed [SUM_W-FRAC_W-1:0] s;
		s = x[SUM_W-1:FRAC_W];
		if (s < 0) begin
			return 8'd0;
		end else if (s > 12'sd255) begin
			return 8'd255;
		end
		return s[7:0];
	endfunction

endpackage

`default_nettype wire

// ===== sv/y2r_if.sv =====
// ----------------------------------------------------------------------------
// y2r interfaces
// Block input, pixel output and configuration write channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface yuv_block_if;
	logic       valid;
	logic       ready;
	logic [7:0] luma_top_left;
	logic [7:0] luma_top_right;
	logic [7:0] luma_bottom_left;
	logic [7:0] luma_bottom_right;
	logic [7:0] chroma_blue;
	logic [7:0] chroma_red;

	modport source (output valid, luma_top_left, luma_top_right, luma_bottom_left,
		luma_bottom_right, chroma_blue, chroma_red, input ready);
	modport sink (input valid, luma_top_left, luma_top_right, luma_bottom_left,
		luma_bottom_right, chroma_blue, chroma_red, output ready);
endinterface

interface rgb_pixel_if;
	logic        valid;
	logic        ready;
	logic [7:0]  red;
	logic [7:0]  green;
	logic [7:0]  blue;
	logic [11:0] pixel_column;
	logic [11:0] pixel_row;
	logic        last_of_block;
	logic        frame_end;

	modport source (output valid, red, green, blue, pixel_column, pixel_row,
		last_of_block, frame_end, input ready);
	modport sink (input valid, red, green, blue, pixel_column, pixel_row,
		last_of_block, frame_end, output ready);
endinterface

interface cfg_write_if;
	logic        valid;
	logic        ready;
	logic [1:0]  index;
	logic [12:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

`default_nettype wire

// ===== sv/yuv420_block_to_rgb.sv =====
// The first pixel of a block passes through the queue, stage one and the output register.
// Each block gives four pixels, one per cycle while the output is not stalled,
// from the single conversion datapath in the back end.
// A two-entry block queue lets the input run ahead of a stalled output.
// Reset clears the position counters, the queue and all valid flags, and loads the
// frame size registers with 176 by 144; no clearing pass is needed.
// ----------------------------------------------------------------------------
// yuv420_block_to_rgb
// BT.601 4:2:0 block to RGB888 converter with frame position tracking.
// ----------------------------------------------------------------------------
`default_nettype none

module yuv420_block_to_rgb #(
	parameter int MAX_DIMENSION = 4096
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	yuv_block_if.sink    blk_in,
	rgb_pixel_if.source  pix_out,
	cfg_write_if.sink    cfg
);
	import y2r_pkg::*;

	localparam logic [DIM_W:0] DIM_MAX = (DIM_W + 1)'(MAX_DIMENSION);
	localparam logic [DIM_W:0] DIM_MIN = (DIM_W + 1)'(2);

	logic [DIM_W-1:0]  width_q;
	logic [DIM_W-1:0]  height_q;
	logic [DIM_W:0]    width_c;
	logic [DIM_W:0]    height_c;
	dims_t             dims;
	q_port_t           push;
	q_port_t           head;
	logic              push_ready;
	logic              pop;

	// Configuration writes are always taken.
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			case (cfg.index)
				CFG_FRAME_WIDTH:  width_q  <= cfg.data;
				CFG_FRAME_HEIGHT: height_q <= cfg.data;
				default: ;
			endcase
		end
	end

	// Frame size clamped to its legal range, then counted in blocks.
	always_comb begin
		width_c  = {1'b0, width_q};
		height_c = {1'b0, height_q};
		if (width_c < DIM_MIN) width_c = DIM_MIN;
		if (width_c > DIM_MAX) width_c = DIM_MAX;
		if (height_c < DIM_MIN) height_c = DIM_MIN;
		if (height_c > DIM_MAX) height_c = DIM_MAX;
		dims.cols = width_c[DIM_W:1];
		dims.rows = height_c[DIM_W:1];
	end

	y2r_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.blk_in     (blk_in),
		.dims       (dims),
		.push       (push),
		.push_ready (push_ready)
	);

	y2r_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_ready (push_ready),
		.head       (head),
		.pop        (pop)
	);

	y2r_back u_back (
		.clk     (clk),
		.arst_n  (arst_n),
		.head    (head),
		.pop     (pop),
		.pix_out (pix_out)
	);

	// The fourth pixel of a block is always its bottom-right one.
	a_last_is_bottom_right: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.last_of_block |->
			pix_out.pixel_column[0] && pix_out.pixel_row[0])
		else $error("last pixel of a block is not the bottom-right pixel");

	// A frame can only end on the last pixel of a block.
	a_frame_end_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		pix_out.valid && pix_out.frame_end |-> pix_out.last_of_block)
		else $error("frame end flagged on a pixel that does not close a block");

	// Nothing is popped from an empty queue.
	a_pop_needs_head: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> head.valid)
		else $error("block queue popped while empty");

endmodule

`default_nettype wire

// ===== sv/y2r_front.sv =====
// ----------------------------------------------------------------------------
// y2r_front
// Accepts a block word, places it in the frame and forms its chroma terms.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_front (
	input  wire logic           clk,
	input  wire logic           arst_n,
	yuv_block_if.sink           blk_in,
	input  wire y2r_pkg::dims_t dims,
	output y2r_pkg::q_port_t    push,
	input  wire logic           push_ready
);
	import y2r_pkg::*;

	logic [CNT_W-1:0]       col_q;
	logic [CNT_W-1:0]       row_q;
	logic [BLK_W-1:0]       col_inc;
	logic [BLK_W-1:0]       row_inc;
	logic                   last_col;
	logic                   last_row;
	logic                   accept;
	logic signed [8:0]      du;
	logic signed [8:0]      dv;

	assign blk_in.ready = push_ready;
	assign accept       = blk_in.valid && push_ready;

	// Place of the block in the frame; a counter past the edge counts as the last block.
	assign col_inc  = BLK_W'(col_q) + BLK_W'(1);
	assign row_inc  = BLK_W'(row_q) + BLK_W'(1);
	assign last_col = col_inc >= dims.cols;
	assign last_row = row_inc >= dims.rows;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (accept) begin
			if (last_col) begin
				col_q <= '0;
				row_q <= last_row ? '0 : row_inc[CNT_W-1:0];
			end else begin
				col_q <= col_inc[CNT_W-1:0];
			end
		end
	end

	// Chroma terms shared by all four pixels of the block.
	assign du = $signed({1'b0, blk_in.chroma_blue}) - CHROMA_OFFSET;
	assign dv = $signed({1'b0, blk_in.chroma_red}) - CHROMA_OFFSET;

	always_comb begin
		push.valid                 = blk_in.valid;
		push.entry.luma[SLOT_TL]   = blk_in.luma_top_left;
		push.entry.luma[SLOT_BL]   = blk_in.luma_bottom_left;
		push.entry.luma[SLOT_TR]   = blk_in.luma_top_right;
		push.entry.luma[SLOT_BR]   = blk_in.luma_bottom_right;
		push.entry.rv              = K_RV * dv;
		push.entry.gu              = K_GU * du;
		push.entry.gv              = K_GV * dv;
		push.entry.bu              = K_BU * du;
		push.entry.col             = col_q;
		push.entry.row             = row_q;
		push.entry.frame_end       = last_col && last_row;
	end

endmodule

`default_nettype wire

// ===== sv/y2r_queue.sv =====
// ----------------------------------------------------------------------------
// y2r_queue
// Short queue of block entries between the front and the back.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_queue (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire y2r_pkg::q_port_t  push,
	output logic                   push_ready,
	output y2r_pkg::q_port_t       head,
	input  wire logic              pop
);
	import y2r_pkg::*;

	blk_entry_t           mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0]   wr_ptr_q;
	logic [Q_PTR_W-1:0]   rd_ptr_q;
	logic [Q_PTR_W:0]     cnt_q;
	logic                 do_push;
	logic                 do_pop;

	assign push_ready = cnt_q != (Q_PTR_W + 1)'(Q_DEPTH);
	assign do_push    = push.valid && push_ready;
	assign do_pop     = pop && (cnt_q != '0);

	assign head.valid = cnt_q != '0;
	assign head.entry = mem_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			mem_q[wr_ptr_q] <= push.entry;
		end
	end

	// Pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == Q_PTR_W'(Q_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (do_pop && !do_push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule

`default_nettype wire

// ===== sv/y2r_back.sv =====
// ----------------------------------------------------------------------------
// y2r_back
// Walks the four pixels of the head block, converting one pixel per cycle unless the output stalls.
// ----------------------------------------------------------------------------
`default_nettype none

module y2r_back (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire y2r_pkg::q_port_t  head,
	output logic                   pop,
	rgb_pixel_if.source            pix_out
);
	import y2r_pkg::*;

	logic [1:0]           pix_q;
	logic                 issue;
	logic                 s1_free;
	logic                 out_load;
	logic signed [8:0]    dy;

	logic                 v_s1;
	term_t                yt_s1;
	term_t                rv_s1;
	term_t                gu_s1;
	term_t                gv_s1;
	term_t                bu_s1;
	logic [COORD_W-1:0]   col_s1;
	logic [COORD_W-1:0]   row_s1;
	logic                 last_s1;
	logic                 fend_s1;

	logic                 out_valid_q;
	term_t                r_sum;
	term_t                g_sum;
	term_t                b_sum;

	// Stall chain: the output register frees stage one, which frees the issue.
	assign out_load = !out_valid_q || pix_out.ready;
	assign s1_free  = !v_s1 || out_load;
	assign issue    = head.valid && s1_free;
	assign pop      = issue && (pix_q == 2'd3);

	assign dy = $signed({1'b0, head.entry.luma[pix_q]}) - LUMA_OFFSET;

	// Pixel index within the head block, and the stage one valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_q <= '0;
			v_s1  <= 1'b0;
		end else begin
			if (issue) begin
				pix_q <= pix_q + 2'd1;
			end
			if (s1_free) begin
				v_s1 <= issue;
			end
		end
	end

	// Stage one: luma product and pixel position.
	always_ff @(posedge clk) begin
		if (issue) begin
			yt_s1   <= K_YT * dy;
			rv_s1   <= head.entry.rv;
			gu_s1   <= head.entry.gu;
			gv_s1   <= head.entry.gv;
			bu_s1   <= head.entry.bu;
			col_s1  <= {head.entry.col, pix_q[1]};
			row_s1  <= {head.entry.row, pix_q[0]};
			last_s1 <= pix_q == 2'd3;
			fend_s1 <= (pix_q == 2'd3) && head.entry.frame_end;
		end
	end

	// Stage two: sums, shift and clamp into the output register.
	assign r_sum = yt_s1 + rv_s1;
	assign g_sum = yt_s1 - gu_s1 - gv_s1;
	assign b_sum = yt_s1 + bu_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load && v_s1) begin
			pix_out.red           <= clamp8(r_sum);
			pix_out.green         <= clamp8(g_sum);
			pix_out.blue          <= clamp8(b_sum);
			pix_out.pixel_column  <= col_s1;
			pix_out.pixel_row     <= row_s1;
			pix_out.last_of_block <= last_s1;
			pix_out.frame_end     <= fend_s1;
		end
	end

	assign pix_out.valid = out_valid_q;

endmodule

`default_nettype wire

// ===== dv/tb_yuv420_block_to_rgb.sv =====
// ----------------------------------------------------------------------------
// tb_yuv420_block_to_rgb
// Self-checking bench for the 4:2:0 block to RGB converter. Each block word
// accepted on the input is run through a fixed-point colour predictor and a
// model of the raster position counters. The four pixel words that the block
// must produce are queued and compared, field by field, with the pixels it
// actually delivers. Directed tests cover sample extremes, tiny frames,
// clamped and odd dimensions and counters left beyond a shrunk frame. A random
// test then walks many frame sizes under bursty input and a stalling output.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_yuv420_block_to_rgb;
	import y2r_pkg::*;

	localparam int MAX_DIM      = 4096;
	localparam int DRAIN_CYCLES = 4;
	localparam int RANDOM_WORDS = 104;

	// BT.601 terms with 16 fraction bits.
	localparam int COEF_LUMA      = 76309;
	localparam int COEF_RED_V     = 104597;
	localparam int COEF_GREEN_U   = 25675;
	localparam int COEF_GREEN_V   = 53279;
	localparam int COEF_BLUE_U    = 132201;
	localparam int LUMA_BLACK     = 16;
	localparam int CHROMA_ZERO    = 128;

	// An index with no register behind it; writes to it must be ignored.
	localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

	typedef struct packed {
		logic [7:0] luma_top_left;
		logic [7:0] luma_top_right;
		logic [7:0] luma_bottom_left;
		logic [7:0] luma_bottom_right;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
	} yuv_block_t;

	typedef struct {
		logic [7:0]         red;
		logic [7:0]         green;
		logic [7:0]         blue;
		logic [COORD_W-1:0] pixel_column;
		logic [COORD_W-1:0] pixel_row;
		logic               last_of_block;
		logic               frame_end;
	} rgb_pixel_t;

	typedef enum {
		SINK_FREE,
		SINK_LIGHT,
		SINK_HALF,
		SINK_CHOKED
	} sink_mode_t;

	logic clk    = 1'b0;
	logic arst_n = 1'b0;

	yuv_block_if  blk();
	rgb_pixel_if  pix();
	cfg_write_if  cfg_bus();

	yuv420_block_to_rgb dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.blk_in  (blk),
		.pix_out (pix),
		.cfg     (cfg_bus)
	);

	// Predictor state: frame size registers and block position counters.
	logic [DIM_W-1:0] width_setting  = WIDTH_RESET;
	logic [DIM_W-1:0] height_setting = HEIGHT_RESET;
	logic [CNT_W-1:0] block_col_pos  = '0;
	logic [CNT_W-1:0] block_row_pos  = '0;
	rgb_pixel_t       pending_pixels[$];
	int               mismatches = 0;

	// Sender burst state.
	int burst_left = 0;
	bit gaps_on    = 1'b1;

	// Receiver stall pattern state.
	sink_mode_t sink_mode = SINK_FREE;
	int         sink_left = 0;

	initial begin
		forever #10 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("FAILURE");
		$finish;
	end

	// Number of blocks along one dimension, after rounding and clamping.
	function automatic int blocks_across(input logic [DIM_W-1:0] dim);
		int d;
		d = dim;
		if (d < 2) d = 2;
		if (d > MAX_DIM) d = MAX_DIM;
		return d / 2;
	endfunction

	// Drop the fraction bits with a floor shift and saturate to a byte.
	function automatic logic [7:0] saturate_channel(input int acc);
		int s;
		s = acc >>> FRAC_W;
		if (s < 0) return 8'd0;
		if (s > 255) return 8'd255;
		return s[7:0];
	endfunction

	// Queue the four pixels of one block and advance the raster position.
	function automatic void predict_block(input yuv_block_t b);
		int               du;
		int               dv;
		int               yt;
		int               cols;
		int               rows;
		logic             last_col;
		logic             last_row;
		logic [7:0]       luma [4];
		rgb_pixel_t       p;
		du = int'(b.chroma_blue) - CHROMA_ZERO;
		dv = int'(b.chroma_red) - CHROMA_ZERO;
		cols = blocks_across(width_setting);
		rows = blocks_across(height_setting);
		last_col = (int'(block_col_pos) + 1) >= cols;
		last_row = (int'(block_row_pos) + 1) >= rows;
		// Pixels leave in column order: top-left, bottom-left, top-right, bottom-right.
		luma[0] = b.luma_top_left;
		luma[1] = b.luma_bottom_left;
		luma[2] = b.luma_top_right;
		luma[3] = b.luma_bottom_right;
		for (int i = 0; i < 4; i++) begin
			yt = COEF_LUMA * (int'(luma[i]) - LUMA_BLACK);
			p.red   = saturate_channel(yt + COEF_RED_V * dv);
			p.green = saturate_channel(yt - COEF_GREEN_U * du - COEF_GREEN_V * dv);
			p.blue  = saturate_channel(yt + COEF_BLUE_U * du);
			p.pixel_column  = {block_col_pos, 1'b0} + COORD_W'(i / 2);
			p.pixel_row     = {block_row_pos, 1'b0} + COORD_W'(i % 2);
			p.last_of_block = (i == 3);
			p.frame_end     = (i == 3) && last_col && last_row;
			pending_pixels.push_back(p);
		end
		// A counter at or beyond its last block wraps at this block.
		if (last_col) begin
			block_col_pos = '0;
			block_row_pos = last_row ? '0 : block_row_pos + 1'b1;
		end else begin
			block_col_pos = block_col_pos + 1'b1;
		end
	endfunction

	function automatic void check_field(input string field, input int want, input int got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			mismatches++;
		end
	endfunction

	// Follow every handshake in a fixed order: register writes, block words,
	// then pixel words against the oldest prediction.
	always @(posedge clk) begin
		yuv_block_t b;
		rgb_pixel_t want;
		if (arst_n) begin
			if (cfg_bus.valid && cfg_bus.ready) begin
				case (cfg_bus.index)
					CFG_FRAME_WIDTH: begin
						width_setting = cfg_bus.data;
					end
					CFG_FRAME_HEIGHT: begin
						height_setting = cfg_bus.data;
					end
					default: begin
					end
				endcase
			end
			if (blk.valid && blk.ready) begin
				b.luma_top_left     = blk.luma_top_left;
				b.luma_top_right    = blk.luma_top_right;
				b.luma_bottom_left  = blk.luma_bottom_left;
				b.luma_bottom_right = blk.luma_bottom_right;
				b.chroma_blue       = blk.chroma_blue;
				b.chroma_red        = blk.chroma_red;
				predict_block(b);
			end
			if (pix.valid && pix.ready) begin
				if (pending_pixels.size() == 0) begin
					$error("pixel word at column %0d row %0d with no block pending",
						pix.pixel_column, pix.pixel_row);
					mismatches++;
				end else begin
					want = pending_pixels.pop_front();
					check_field("red", want.red, pix.red);
					check_field("green", want.green, pix.green);
					check_field("blue", want.blue, pix.blue);
					check_field("pixel_column", want.pixel_column, pix.pixel_column);
					check_field("pixel_row", want.pixel_row, pix.pixel_row);
					check_field("last_of_block", want.last_of_block, pix.last_of_block);
					check_field("frame_end", want.frame_end, pix.frame_end);
				end
			end
		end
	end

	// Output back-pressure: a random stall pattern, picked anew at random times.
	always @(posedge clk) begin
		if (sink_left == 0) begin
			sink_mode = sink_mode_t'($urandom_range(0, 3));
			sink_left = $urandom_range(16, 96);
		end
		sink_left--;
		case (sink_mode)
			SINK_FREE: begin
				pix.ready <= 1'b1;
			end
			SINK_LIGHT: begin
				pix.ready <= ($urandom_range(0, 3) != 0);
			end
			SINK_HALF: begin
				pix.ready <= 1'($urandom_range(0, 1));
			end
			default: begin
				pix.ready <= (sink_left % 12) < 3;
			end
		endcase
	end

	// A sample that lands on an extreme or a neutral point now and then.
	function automatic logic [7:0] random_sample();
		case ($urandom_range(0, 9))
			0: return 8'd0;
			1: return 8'd255;
			2: return 8'd16;
			3: return 8'd128;
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	function automatic yuv_block_t random_block();
		yuv_block_t b;
		b.luma_top_left     = random_sample();
		b.luma_top_right    = random_sample();
		b.luma_bottom_left  = random_sample();
		b.luma_bottom_right = random_sample();
		b.chroma_blue       = random_sample();
		b.chroma_red        = random_sample();
		return b;
	endfunction

	// Mostly small frames so that frames end often, with the odd extreme size.
	function automatic logic [DIM_W-1:0] random_dimension();
		if ($urandom_range(0, 4) != 0) return DIM_W'($urandom_range(0, 20));
		case ($urandom_range(0, 3))
			0: return DIM_W'(MAX_DIM);
			1: return DIM_W'(MAX_DIM + 1);
			2: return '1;
			default: return DIM_W'($urandom_range(0, 8191));
		endcase
	endfunction

	// Send one block word. A new burst may open with a gap; valid stays high
	// after acceptance so that words can follow back to back.
	task automatic send_block(input yuv_block_t b);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 8);
			gap = gaps_on ? $urandom_range(1, 6) : 0;
			if (gap > 0) begin
				blk.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		blk.valid             <= 1'b1;
		blk.luma_top_left     <= b.luma_top_left;
		blk.luma_top_right    <= b.luma_top_right;
		blk.luma_bottom_left  <= b.luma_bottom_left;
		blk.luma_bottom_right <= b.luma_bottom_right;
		blk.chroma_blue       <= b.chroma_blue;
		blk.chroma_red        <= b.chroma_red;
		do @(posedge clk); while (!blk.ready);
	endtask

	// Stop sending and wait for every predicted pixel to arrive.
	task automatic wait_drained();
		blk.valid <= 1'b0;
		burst_left = 0;
		@(posedge clk);
		while (pending_pixels.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	// Register write; valid is left high so writes can follow back to back.
	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [DIM_W-1:0] value);
		cfg_bus.valid <= 1'b1;
		cfg_bus.index <= idx;
		cfg_bus.data  <= value;
		do @(posedge clk); while (!cfg_bus.ready);
	endtask

	task automatic set_frame(input logic [DIM_W-1:0] w, input logic [DIM_W-1:0] h);
		write_reg(CFG_FRAME_WIDTH, w);
		write_reg(CFG_FRAME_HEIGHT, h);
		cfg_bus.valid <= 1'b0;
	endtask

	// Sample extremes in the reset frame: clamping at both ends, neutral grey
	// points, and distinct lumas to pin down the pixel order.
	task automatic test_sample_extremes();
		yuv_block_t cases [8];
		cases[0] = '{8'd0, 8'd0, 8'd0, 8'd0, 8'd0, 8'd0};
		cases[1] = '{8'd255, 8'd255, 8'd255, 8'd255, 8'd255, 8'd255};
		cases[2] = '{8'd16, 8'd16, 8'd16, 8'd16, 8'd128, 8'd128};
		cases[3] = '{8'd235, 8'd235, 8'd235, 8'd235, 8'd128, 8'd128};
		cases[4] = '{8'd255, 8'd0, 8'd255, 8'd0, 8'd0, 8'd255};
		cases[5] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd255, 8'd0};
		cases[6] = '{8'd10, 8'd80, 8'd160, 8'd240, 8'd90, 8'd200};
		cases[7] = '{8'd128, 8'd170, 8'd85, 8'd127, 8'd255, 8'd255};
		foreach (cases[i]) send_block(cases[i]);
		wait_drained();
	endtask

	// Smallest frames: every block of a 2x2 frame ends the frame.
	task automatic test_tiny_frames();
		set_frame(13'd2, 13'd2);
		repeat (3) send_block(random_block());
		wait_drained();
		set_frame(13'd4, 13'd2);
		repeat (3) send_block(random_block());
		wait_drained();
	endtask

	// Sizes below the minimum, odd sizes and sizes above the maximum, plus a
	// write to an index that holds no register.
	task automatic test_dimension_clamps();
		write_reg(CFG_SPARE, '1);
		set_frame(13'd0, 13'd1);
		repeat (2) send_block(random_block());
		wait_drained();
		set_frame(13'd7, 13'd5);
		repeat (2) send_block(random_block());
		wait_drained();
		set_frame('1, DIM_W'(MAX_DIM + 1));
		repeat (2) send_block(random_block());
		wait_drained();
	endtask

	// Shrink the width while the column counter sits past the new last block.
	task automatic test_counter_beyond_frame();
		set_frame(13'd16, 13'd8);
		repeat (4) send_block(random_block());
		wait_drained();
		set_frame(13'd6, 13'd8);
		repeat (2) send_block(random_block());
		wait_drained();
	endtask

	// Random frame sizes, each followed by a run of random blocks.
	task automatic test_random_frames();
		int remaining;
		int n;
		remaining = RANDOM_WORDS;
		while (remaining > 0) begin
			set_frame(random_dimension(), random_dimension());
			gaps_on = ($urandom_range(0, 3) != 0);
			n = $urandom_range(4, 20);
			if (n > remaining) n = remaining;
			repeat (n) send_block(random_block());
			remaining -= n;
			wait_drained();
		end
		gaps_on = 1'b1;
	endtask

	initial begin
		blk.valid             = 1'b0;
		blk.luma_top_left     = '0;
		blk.luma_top_right    = '0;
		blk.luma_bottom_left  = '0;
		blk.luma_bottom_right = '0;
		blk.chroma_blue       = '0;
		blk.chroma_red        = '0;
		pix.ready             = 1'b0;
		cfg_bus.valid         = 1'b0;
		cfg_bus.index         = CFG_FRAME_WIDTH;
		cfg_bus.data          = '0;
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		test_sample_extremes();
		test_tiny_frames();
		test_dimension_clamps();
		test_counter_beyond_frame();
		test_random_frames();
		if (mismatches == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/y2r_pkg.sv
sv/y2r_if.sv
sv/y2r_front.sv
sv/y2r_queue.sv
sv/y2r_back.sv
sv/yuv420_block_to_rgb.sv
dv/tb_yuv420_block_to_rgb.sv
